@@ design/tkbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbc_pkg
// shared types, codes and helpers for the table keystream block cipher
// ----------------------------------------------------------------------------
package tkbc_pkg;

   typedef logic [1:0]  kind_type;
   typedef logic [31:0] word_type;
   typedef logic [7:0]  index_type;
   typedef logic [2:0]  reg_sel_type;

   // transaction kinds
   localparam kind_type KIND_LOAD    = 2'd0;
   localparam kind_type KIND_RESTART = 2'd1;
   localparam kind_type KIND_BLOCK   = 2'd2;

   // register map, index = byte address / 4
   localparam int unsigned CSR_ADDR_W = 5;
   localparam reg_sel_type REG_CIPHER_MODE  = 3'd0;
   localparam reg_sel_type REG_DIRECTION    = 3'd1;
   localparam reg_sel_type REG_TABLE_LOG2   = 3'd2;
   localparam reg_sel_type REG_START_WORD   = 3'd3;
   localparam reg_sel_type REG_START_FIRST  = 3'd4;
   localparam reg_sel_type REG_START_SECOND = 3'd5;

   localparam logic [3:0] TABLE_LOG2_MIN   = 4'd4;
   localparam logic [3:0] TABLE_LOG2_RESET = 4'd4;

   localparam logic [1:0] STEP_FIRST = 2'd0;
   localparam logic [1:0] STEP_LAST  = 2'd3;

   // xor of the four bytes of a word
   function automatic index_type fold8(input word_type v);
      return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
   endfunction

endpackage

@@ design/tkbc_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbc channel interfaces
// valid/ready channels for request and response transactions
// ----------------------------------------------------------------------------
interface tkbc_req_if;
   logic                 valid;
   logic                 ready;
   tkbc_pkg::kind_type   kind;
   tkbc_pkg::index_type  table_index;
   tkbc_pkg::word_type   table_word;
   tkbc_pkg::word_type   word0;
   tkbc_pkg::word_type   word1;
   tkbc_pkg::word_type   word2;
   tkbc_pkg::word_type   word3;

   modport source (output valid, kind, table_index, table_word, word0, word1, word2, word3,
                   input ready);
   modport sink   (input valid, kind, table_index, table_word, word0, word1, word2, word3,
                   output ready);
endinterface

interface tkbc_rsp_if;
   logic                 valid;
   logic                 ready;
   tkbc_pkg::word_type   out_word0;
   tkbc_pkg::word_type   out_word1;
   tkbc_pkg::word_type   out_word2;
   tkbc_pkg::word_type   out_word3;

   modport source (output valid, out_word0, out_word1, out_word2, out_word3, input ready);
   modport sink   (input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface

@@ design/table_keystream_block_cipher_unit.sv @@
`timescale 1ns / 1ps
// a block transaction gives its response once its last step finishes and the response
//   register is free; no new request is taken mid-walk, the pace being set by the chain
//   of four dependent synchronous key table reads whose data forms the next address
// load and restart transactions give no response
// reset: synchronous, clears control, registers, feedback words and indices; the key
//   table is not cleared and holds undefined data until loaded
// ----------------------------------------------------------------------------
// table_keystream_block_cipher_unit
// key table in a synchronous ram, walked four times per block to build an xor
// keystream; simple and chained (past) modes, encrypt and decrypt
// ----------------------------------------------------------------------------
module table_keystream_block_cipher_unit #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   tkbc_req_if.sink                            req_chan,
   tkbc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tkbc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   // configuration registers
   logic                 cipher_mode_ff;
   logic                 direction_ff;
   logic [3:0]           table_log2_ff;
   tkbc_pkg::word_type   start_word_ff;
   tkbc_pkg::index_type  start_first_ff;
   tkbc_pkg::index_type  start_second_ff;

   // control and cipher state
   state_type            state_ff, state_in;
   logic [1:0]           step_ff, step_in;
   tkbc_pkg::index_type  first_index_ff, second_index_ff;
   tkbc_pkg::word_type   fb0_ff, fb1_ff, fb2_ff, fb3_ff;
   tkbc_pkg::index_type  e_ff;
   tkbc_pkg::word_type   w0_ff, w1_ff, w2_ff, w3_ff;
   tkbc_pkg::word_type   r0_ff, r1_ff, r2_ff;
   logic                 rsp_valid_ff;
   tkbc_pkg::word_type   out0_ff, out1_ff, out2_ff, out3_ff;

   // key table
   tkbc_pkg::word_type   key_mem [TABLE_DEPTH];
   tkbc_pkg::word_type   mem_rdata_ff;
   logic                 mem_re, mem_we;
   logic [AW-1:0]        mem_raddr, mem_waddr;

   logic                 csr_write;
   tkbc_pkg::reg_sel_type csr_sel;
   logic [3:0]           lg_sat;
   tkbc_pkg::index_type  mask;
   logic                 req_fire, blk_accept, load_accept, rst_accept;
   logic                 walking, last_step, out_free, finish;
   tkbc_pkg::word_type   fb_walk, fb_out, word_cur, kw, res;
   tkbc_pkg::index_type  p, e_nx, f_nx, e0, f0;

   // ------------------------------------------------------------------ csr
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      unique case (csr_sel)
         tkbc_pkg::REG_CIPHER_MODE:  csr_prdata = {31'd0, cipher_mode_ff};
         tkbc_pkg::REG_DIRECTION:    csr_prdata = {31'd0, direction_ff};
         tkbc_pkg::REG_TABLE_LOG2:   csr_prdata = {28'd0, table_log2_ff};
         tkbc_pkg::REG_START_WORD:   csr_prdata = start_word_ff;
         tkbc_pkg::REG_START_FIRST:  csr_prdata = {24'd0, start_first_ff};
         tkbc_pkg::REG_START_SECOND: csr_prdata = {24'd0, start_second_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_mode_ff  <= 1'b0;
         direction_ff    <= 1'b0;
         table_log2_ff   <= tkbc_pkg::TABLE_LOG2_RESET;
         start_word_ff   <= '0;
         start_first_ff  <= '0;
         start_second_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_sel)
            tkbc_pkg::REG_CIPHER_MODE:  cipher_mode_ff  <= csr_pwdata[0];
            tkbc_pkg::REG_DIRECTION:    direction_ff    <= csr_pwdata[0];
            tkbc_pkg::REG_TABLE_LOG2:   table_log2_ff   <= csr_pwdata[3:0];
            tkbc_pkg::REG_START_WORD:   start_word_ff   <= csr_pwdata;
            tkbc_pkg::REG_START_FIRST:  start_first_ff  <= csr_pwdata[7:0];
            tkbc_pkg::REG_START_SECOND: start_second_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // index mask, table size saturated to the usable range
   always_comb begin
      priority if (table_log2_ff < tkbc_pkg::TABLE_LOG2_MIN) begin
         lg_sat = tkbc_pkg::TABLE_LOG2_MIN;
      end else if (table_log2_ff > 4'(AW)) begin
         lg_sat = 4'(AW);
      end else begin
         lg_sat = table_log2_ff;
      end
      mask = 8'((9'd1 << lg_sat) - 9'd1);
   end

   // ------------------------------------------------------------ handshake
   assign walking     = (state_ff == ST_WALK);
   assign last_step   = walking && (step_ff == tkbc_pkg::STEP_LAST);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign finish      = last_step && out_free;
   assign req_chan.ready = (state_ff == ST_IDLE) || finish;
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign blk_accept  = req_fire && (req_chan.kind == tkbc_pkg::KIND_BLOCK);
   assign load_accept = req_fire && (req_chan.kind == tkbc_pkg::KIND_LOAD);
   assign rst_accept  = req_fire && (req_chan.kind == tkbc_pkg::KIND_RESTART);

   // ------------------------------------------------------------ walk step
   always_comb begin
      fb_walk  = '0;
      fb_out   = '0;
      word_cur = w0_ff;
      unique case (step_ff)
         2'd0: begin
            fb_walk  = fb2_ff;
            fb_out   = fb0_ff;
            word_cur = w0_ff;
         end
         2'd1: begin
            fb_walk  = fb0_ff;
            fb_out   = fb1_ff;
            word_cur = w1_ff;
         end
         2'd2: begin
            fb_walk  = fb3_ff;
            fb_out   = fb2_ff;
            word_cur = w2_ff;
         end
         2'd3: begin
            fb_walk  = fb1_ff;
            fb_out   = fb3_ff;
            word_cur = w3_ff;
         end
      endcase
      if (!cipher_mode_ff) begin
         fb_walk = '0;
         fb_out  = '0;
      end
      kw   = fb_walk ^ mem_rdata_ff;
      p    = tkbc_pkg::fold8(kw) & mask;
      e_nx = p;
      f_nx = e_ff ^ p;
      res  = word_cur ^ kw ^ fb_out;
   end

   // start indices: the start registers in simple mode, else forwarded from a block finishing in the same cycle
   always_comb begin
      if (!cipher_mode_ff) begin
         e0 = start_first_ff;
         f0 = start_second_ff;
      end else if (last_step) begin
         e0 = e_nx;
         f0 = f_nx;
      end else begin
         e0 = first_index_ff;
         f0 = second_index_ff;
      end
   end

   // ------------------------------------------------------------ key table
   assign mem_re    = blk_accept || (walking && (step_ff != tkbc_pkg::STEP_LAST));
   assign mem_raddr = blk_accept ? AW'(f0 & mask) : AW'(f_nx & mask);
   assign mem_we    = load_accept;
   assign mem_waddr = req_chan.table_index[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= req_chan.table_word;
      end
      if (mem_re) begin
         mem_rdata_ff <= key_mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (blk_accept) begin
               state_in = ST_WALK;
               step_in  = tkbc_pkg::STEP_FIRST;
            end
         end
         ST_WALK: begin
            if (step_ff != tkbc_pkg::STEP_LAST) begin
               step_in = step_ff + 2'd1;
            end else if (finish) begin
               state_in = blk_accept ? ST_WALK : ST_IDLE;
               step_in  = tkbc_pkg::STEP_FIRST;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = tkbc_pkg::STEP_FIRST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= tkbc_pkg::STEP_FIRST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // cipher state; a restart is later than a finishing block and wins
   always_ff @(posedge clock) begin
      if (reset) begin
         first_index_ff  <= '0;
         second_index_ff <= '0;
         fb0_ff          <= '0;
         fb1_ff          <= '0;
         fb2_ff          <= '0;
         fb3_ff          <= '0;
      end else if (rst_accept) begin
         fb0_ff          <= start_word_ff ^ req_chan.word0;
         fb1_ff          <= start_word_ff ^ req_chan.word1;
         fb2_ff          <= start_word_ff ^ req_chan.word2;
         fb3_ff          <= start_word_ff ^ req_chan.word3;
         first_index_ff  <= (start_first_ff ^ tkbc_pkg::fold8(req_chan.word0 ^ req_chan.word2))
                            & mask;
         second_index_ff <= (start_second_ff ^ tkbc_pkg::fold8(req_chan.word1 ^ req_chan.word3))
                            & mask;
      end else if (finish) begin
         first_index_ff  <= e_nx;
         second_index_ff <= f_nx;
         if (cipher_mode_ff) begin
            if (!direction_ff) begin
               fb0_ff <= r0_ff;
               fb1_ff <= r1_ff;
               fb2_ff <= r2_ff;
               fb3_ff <= res;
            end else begin
               fb0_ff <= w0_ff;
               fb1_ff <= w1_ff;
               fb2_ff <= w2_ff;
               fb3_ff <= w3_ff;
            end
         end
      end
   end

   // walk datapath
   always_ff @(posedge clock) begin
      if (blk_accept) begin
         e_ff  <= e0;
         w0_ff <= req_chan.word0;
         w1_ff <= req_chan.word1;
         w2_ff <= req_chan.word2;
         w3_ff <= req_chan.word3;
      end else if (walking && (step_ff != tkbc_pkg::STEP_LAST)) begin
         e_ff <= e_nx;
      end
      if (walking) begin
         unique case (step_ff)
            2'd0: r0_ff <= res;
            2'd1: r1_ff <= res;
            2'd2: r2_ff <= res;
            2'd3: ;
         endcase
      end
   end

   // ------------------------------------------------------------ response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         out0_ff <= r0_ff;
         out1_ff <= r1_ff;
         out2_ff <= r2_ff;
         out3_ff <= res;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_word0 = out0_ff;
   assign rsp_chan.out_word1 = out1_ff;
   assign rsp_chan.out_word2 = out2_ff;
   assign rsp_chan.out_word3 = out3_ff;

`ifndef SYNTH
   // no new transaction while a block is mid-walk
   a_no_accept_mid_walk: assert property (@(posedge clock) disable iff (reset)
      (walking && (step_ff != tkbc_pkg::STEP_LAST)) |-> !req_chan.ready)
      else $error("request accepted during table walk");

   // an accepted block starts its walk on the next cycle
   a_block_starts_walk: assert property (@(posedge clock) disable iff (reset)
      blk_accept |=> (state_ff == ST_WALK && step_ff == tkbc_pkg::STEP_FIRST))
      else $error("block did not start walking");

   // a stalled final step holds until the response register frees up
   a_final_step_holds: assert property (@(posedge clock) disable iff (reset)
      (last_step && !out_free) |=> last_step)
      else $error("final step lost under back-pressure");

   // table load and table walk never share a cycle
   a_no_read_write_clash: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !mem_re)
      else $error("key table read and write in the same cycle");

   // a finishing block always leaves a valid response
   a_finish_gives_response: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished block produced no response");
`endif

endmodule

@@ bench/tb_table_keystream_block_cipher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_keystream_block_cipher_unit
// drives load, restart, block and unused transactions into the cipher unit and
// checks every block response against a cycle-free predictor of the keystream
// walk. registers are set over the csr port between phases. directed cases
// cover extreme words, both modes and directions, out of range table sizes and
// oversized or stale indices. random phases follow, with random gaps on both
// channels. table entries a block would read are loaded before the block is sent
// ----------------------------------------------------------------------------
module tb_table_keystream_block_cipher_unit;

   localparam int unsigned        DEPTH        = 256;
   localparam int                 CYCLE_LIMIT  = 1000000;
   localparam int                 DRAIN_CYCLES = 8;
   localparam int                 ITEM_TARGET  = 1000;
   localparam tkbc_pkg::kind_type KIND_UNUSED  = 2'd3;

   typedef logic [3:0][31:0] block_out_type;

   typedef struct packed {
      tkbc_pkg::kind_type  kind;
      tkbc_pkg::index_type table_index;
      tkbc_pkg::word_type  table_word;
      tkbc_pkg::word_type  w0;
      tkbc_pkg::word_type  w1;
      tkbc_pkg::word_type  w2;
      tkbc_pkg::word_type  w3;
   } cipher_req_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [tkbc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   tkbc_req_if req_chan ();
   tkbc_rsp_if rsp_chan ();

   table_keystream_block_cipher_unit #(
      .TABLE_DEPTH (DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   tkbc_pkg::word_type  key_mem [DEPTH];
   bit                  key_loaded [DEPTH];
   tkbc_pkg::word_type  chain_fb [4] = '{default: '0};
   tkbc_pkg::index_type walk_first = '0;
   tkbc_pkg::index_type walk_second = '0;
   bit                  mode_past;
   bit                  dir_decrypt;
   logic [3:0]          size_log2 = tkbc_pkg::TABLE_LOG2_RESET;
   tkbc_pkg::word_type  start_word_q = '0;
   tkbc_pkg::index_type start_first_q = '0;
   tkbc_pkg::index_type start_second_q = '0;

   block_out_type expected_blocks [$];
   int            fail_count = 0;
   int            items_accepted = 0;
   int            cycle_count = 0;
   bit            no_gaps = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_table_keystream_block_cipher_unit: FAIL");
         $finish;
      end
   end

   function automatic tkbc_pkg::index_type byte_xor(input tkbc_pkg::word_type v);
      return v[31:24] ^ v[23:16] ^ v[15:8] ^ v[7:0];
   endfunction

   function automatic tkbc_pkg::index_type walk_mask();
      logic [3:0] lg;
      lg = size_log2;
      if (lg < 4'd4) lg = 4'd4;
      else if (lg > 4'd8) lg = 4'd8;
      return tkbc_pkg::index_type'((9'd1 << lg) - 9'd1);
   endfunction

   function automatic tkbc_pkg::word_type key_step(inout tkbc_pkg::index_type e,
                                                   inout tkbc_pkg::index_type f,
                                                   input tkbc_pkg::word_type fb,
                                                   input tkbc_pkg::index_type m);
      tkbc_pkg::word_type  w;
      tkbc_pkg::index_type p;
      w = fb ^ key_mem[f & m];
      p = byte_xor(w) & m;
      f = e ^ p;
      e = p;
      return w;
   endfunction

   // first table entry the next block would read while still unloaded, else -1
   function automatic int unloaded_key_read();
      tkbc_pkg::index_type e;
      tkbc_pkg::index_type f;
      tkbc_pkg::index_type m;
      tkbc_pkg::word_type  fb [4];
      int                  k;
      m = walk_mask();
      if (mode_past) begin
         e = walk_first;
         f = walk_second;
         fb = '{chain_fb[2], chain_fb[0], chain_fb[3], chain_fb[1]};
      end else begin
         e = start_first_q;
         f = start_second_q;
         fb = '{default: '0};
      end
      for (k = 0; k < 4; k++) begin
         if (!key_loaded[f & m]) return int'(f & m);
         void'(key_step(e, f, fb[k], m));
      end
      return -1;
   endfunction

   function automatic bit cipher_predict(input cipher_req_type it,
                                         output block_out_type res);
      tkbc_pkg::index_type e;
      tkbc_pkg::index_type f;
      tkbc_pkg::index_type m;
      tkbc_pkg::word_type  k [4];
      tkbc_pkg::word_type  d [4];
      int                  i;
      m = walk_mask();
      res = '0;
      d = '{it.w0, it.w1, it.w2, it.w3};
      case (it.kind)
         tkbc_pkg::KIND_LOAD: begin
            key_mem[it.table_index] = it.table_word;
            key_loaded[it.table_index] = 1'b1;
            return 1'b0;
         end
         tkbc_pkg::KIND_RESTART: begin
            for (i = 0; i < 4; i++) chain_fb[i] = start_word_q ^ d[i];
            walk_first = (start_first_q ^ byte_xor(d[0] ^ d[2])) & m;
            walk_second = (start_second_q ^ byte_xor(d[1] ^ d[3])) & m;
            return 1'b0;
         end
         tkbc_pkg::KIND_BLOCK: begin
            if (!mode_past) begin
               e = start_first_q;
               f = start_second_q;
               for (i = 0; i < 4; i++) k[i] = key_step(e, f, '0, m);
               for (i = 0; i < 4; i++) res[i] = d[i] ^ k[i];
            end else begin
               e = walk_first;
               f = walk_second;
               k[0] = key_step(e, f, chain_fb[2], m);
               k[1] = key_step(e, f, chain_fb[0], m);
               k[2] = key_step(e, f, chain_fb[3], m);
               k[3] = key_step(e, f, chain_fb[1], m);
               for (i = 0; i < 4; i++) res[i] = d[i] ^ k[i] ^ chain_fb[i];
               for (i = 0; i < 4; i++) chain_fb[i] = dir_decrypt ? d[i] : res[i];
            end
            walk_first = e;
            walk_second = f;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic int pick_pause();
      int r;
      if (no_gaps) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 96) return int'($urandom_range(4, 10));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic tkbc_pkg::word_type rand_word();
      int r;
      r = int'($urandom_range(0, 9));
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // response side: ready with random stalls, result checking
   initial begin : response_check
      int            pause;
      int            i;
      block_out_type want;
      block_out_type got;
      pause = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.out_word3, rsp_chan.out_word2, rsp_chan.out_word1,
                   rsp_chan.out_word0};
            if (expected_blocks.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response transaction: %08h %08h %08h %08h",
                           got[0], got[1], got[2], got[3]);
            end else begin
               want = expected_blocks.pop_front();
               for (i = 0; i < 4; i++) begin
                  if (got[i] !== want[i]) begin
                     fail_count++;
                     if (fail_count <= 10)
                        $display("mismatch out_word%0d: expected %08h, actual %08h",
                                 i, want[i], got[i]);
                  end
               end
            end
         end
         if (pause > 0) begin
            pause--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            pause = pick_pause();
         end
      end
   end

   task automatic send_item(input cipher_req_type it);
      int            gap;
      block_out_type res;
      gap = pick_pause();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= it.kind;
      req_chan.table_index <= it.table_index;
      req_chan.table_word  <= it.table_word;
      req_chan.word0       <= it.w0;
      req_chan.word1       <= it.w1;
      req_chan.word2       <= it.w2;
      req_chan.word3       <= it.w3;
      do @(posedge clock); while (!req_chan.ready);
      if (cipher_predict(it, res)) expected_blocks.push_back(res);
      if (it.kind != KIND_UNUSED) items_accepted++;
   endtask

   task automatic send_load(input tkbc_pkg::index_type idx, input tkbc_pkg::word_type value);
      cipher_req_type it;
      it = '0;
      it.kind = tkbc_pkg::KIND_LOAD;
      it.table_index = idx;
      it.table_word = value;
      send_item(it);
   endtask

   task automatic send_restart(input tkbc_pkg::word_type iv0, input tkbc_pkg::word_type iv1,
                               input tkbc_pkg::word_type iv2, input tkbc_pkg::word_type iv3);
      cipher_req_type it;
      it = '0;
      it.kind = tkbc_pkg::KIND_RESTART;
      it.table_index = tkbc_pkg::index_type'($urandom);
      it.table_word = $urandom;
      it.w0 = iv0;
      it.w1 = iv1;
      it.w2 = iv2;
      it.w3 = iv3;
      send_item(it);
   endtask

   // loads any entry the walk would reach before it is written, then the block
   task automatic send_block(input tkbc_pkg::word_type d0, input tkbc_pkg::word_type d1,
                             input tkbc_pkg::word_type d2, input tkbc_pkg::word_type d3);
      cipher_req_type it;
      int             idx;
      forever begin
         idx = unloaded_key_read();
         if (idx < 0) break;
         send_load(tkbc_pkg::index_type'(idx), rand_word());
      end
      it = '0;
      it.kind = tkbc_pkg::KIND_BLOCK;
      it.table_index = tkbc_pkg::index_type'($urandom);
      it.table_word = $urandom;
      it.w0 = d0;
      it.w1 = d1;
      it.w2 = d2;
      it.w3 = d3;
      send_item(it);
   endtask

   task automatic send_unused();
      cipher_req_type it;
      it.kind = KIND_UNUSED;
      it.table_index = tkbc_pkg::index_type'($urandom);
      it.table_word = rand_word();
      it.w0 = rand_word();
      it.w1 = rand_word();
      it.w2 = rand_word();
      it.w3 = rand_word();
      send_item(it);
   endtask

   task automatic send_random_block();
      send_block(rand_word(), rand_word(), rand_word(), rand_word());
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input tkbc_pkg::reg_sel_type sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (sel)
         tkbc_pkg::REG_CIPHER_MODE:  mode_past      = value[0];
         tkbc_pkg::REG_DIRECTION:    dir_decrypt    = value[0];
         tkbc_pkg::REG_TABLE_LOG2:   size_log2      = value[3:0];
         tkbc_pkg::REG_START_WORD:   start_word_q   = value;
         tkbc_pkg::REG_START_FIRST:  start_first_q  = value[7:0];
         tkbc_pkg::REG_START_SECOND: start_second_q = value[7:0];
         default: ;
      endcase
   endtask

   task automatic write_config(input bit mode, input bit dir, input logic [3:0] lg,
                               input tkbc_pkg::word_type sw, input tkbc_pkg::index_type sf,
                               input tkbc_pkg::index_type ss);
      csr_write(tkbc_pkg::REG_CIPHER_MODE, 32'(mode));
      csr_write(tkbc_pkg::REG_DIRECTION, 32'(dir));
      csr_write(tkbc_pkg::REG_TABLE_LOG2, 32'(lg));
      csr_write(tkbc_pkg::REG_START_WORD, sw);
      csr_write(tkbc_pkg::REG_START_FIRST, 32'(sf));
      csr_write(tkbc_pkg::REG_START_SECOND, 32'(ss));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic test_simple_mode();
      write_config(1'b0, 1'b0, 4'd4, '0, 8'd0, 8'd0);
      send_load(8'hFF, '1);
      send_load(8'h00, '0);
      send_block('0, '0, '0, '0);
      send_block('1, '1, '1, '1);
      send_unused();
      send_block(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
   endtask

   task automatic test_past_mode();
      drain();
      write_config(1'b1, 1'b0, 4'd5, '1, 8'd3, 8'd17);
      send_restart('0, '1, '0, '1);
      send_block('1, '0, '1, '0);
      send_random_block();
      drain();
      write_config(1'b1, 1'b1, 4'd5, 32'h5A5A_A5A5, 8'd200, 8'd1);
      send_restart(rand_word(), rand_word(), rand_word(), rand_word());
      send_random_block();
      send_block('0, '0, '0, '0);
   endtask

   // saturated table sizes, oversized start indices, stale indices after a size change
   task automatic test_size_limits();
      drain();
      write_config(1'b0, 1'b0, 4'd0, '0, 8'hFF, 8'hFF);
      send_random_block();
      drain();
      write_config(1'b0, 1'b1, 4'd15, '1, 8'hFF, 8'h80);
      send_random_block();
      send_random_block();
      drain();
      write_config(1'b1, 1'b0, 4'd4, '0, 8'd0, 8'd0);
      send_random_block();
      send_restart('1, '1, '1, '1);
      send_random_block();
   endtask

   task automatic test_random_traffic();
      int         first_count;
      int         phase_end;
      int         r;
      logic [3:0] lg;
      first_count = items_accepted;
      while (items_accepted - first_count < ITEM_TARGET) begin
         drain();
         if ($urandom_range(0, 99) < 40) lg = 4'($urandom_range(0, 15));
         else lg = 4'($urandom_range(4, 6));
         write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), lg, rand_word(),
                      tkbc_pkg::index_type'($urandom_range(0, 255)),
                      tkbc_pkg::index_type'($urandom_range(0, 255)));
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1)
            send_restart(rand_word(), rand_word(), rand_word(), rand_word());
         phase_end = items_accepted + int'($urandom_range(60, 140));
         while (items_accepted < phase_end) begin
            r = int'($urandom_range(0, 99));
            if (r < 10) send_restart(rand_word(), rand_word(), rand_word(), rand_word());
            else if (r < 18)
               send_load(tkbc_pkg::index_type'($urandom_range(0, 255)), rand_word());
            else if (r < 21) send_unused();
            else if (r < 23) drain();
            else send_random_block();
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      reset                <= 1'b1;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.kind        <= tkbc_pkg::KIND_LOAD;
      req_chan.table_index <= '0;
      req_chan.table_word  <= '0;
      req_chan.word0       <= '0;
      req_chan.word1       <= '0;
      req_chan.word2       <= '0;
      req_chan.word3       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_simple_mode();
      test_past_mode();
      test_size_limits();
      test_random_traffic();
      drain();
      repeat (12) @(posedge clock);
      if (fail_count == 0 && expected_blocks.size() == 0) begin
         $display("tb_table_keystream_block_cipher_unit: PASS");
      end else begin
         $display("tb_table_keystream_block_cipher_unit: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/tkbc_pkg.sv
design/tkbc_ifs.sv
design/table_keystream_block_cipher_unit.sv
bench/tb_table_keystream_block_cipher_unit.sv
